// File: rtl/mrucd_pkg.sv
// Package for the MRU cache directory: shared widths, register map and cell control type.
// Used by every module under rtl; it depends on nothing else.
package mrucd_pkg;

  // Key and occupancy widths fixed by the interface.
  localparam int KEY_W  = 8;
  localparam int CNT_W  = 5;
  localparam int CTR_W  = 32;

  // Result payload layout, lowest bit first.
  localparam int OUT_BITS   = 1 + 1 + KEY_W + CTR_W + CTR_W + CNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_CAPACITY_ADDR = 3'd0;
  localparam logic [CNT_W-1:0]      CAPACITY_RESET    = 5'd16;

  // Per-cell update command.
  typedef struct packed {
    logic load;   // take the looked-up key (front cell only)
    logic shift;  // take the key of the more recent neighbor
  } mrucd_cell_ctrl_t;

endpackage

// File: rtl/mrucd_cell.sv
// One directory cell: holds a single key and compares it with the lookup key.
// Depends on mrucd_pkg for the key width and the cell control struct.
module mrucd_cell (
  input  logic                            clk,
  input  logic                            entry_valid,
  input  logic [mrucd_pkg::KEY_W-1:0]     lookup_key,
  input  logic [mrucd_pkg::KEY_W-1:0]     neighbor_key,
  input  mrucd_pkg::mrucd_cell_ctrl_t     ctrl,
  output logic [mrucd_pkg::KEY_W-1:0]     key,
  output logic                            match
);
  import mrucd_pkg::*;

  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] key_nxt;

  // Load the new key at the front, or take the neighbor's key when shifting down.
  always_comb begin
    key_nxt = key_r;
    if (ctrl.load) begin
      key_nxt = lookup_key;
    end else if (ctrl.shift) begin
      key_nxt = neighbor_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  // Only occupied cells take part in the lookup.
  assign match = entry_valid && (key_r == lookup_key);
  assign key   = key_r;

endmodule

// File: rtl/mrucd_pos_enc.sv
// Turns the one-hot match vector of the cell row into a hit flag and a position.
// Depends on mrucd_pkg only through the common import style.
module mrucd_pos_enc #(
  parameter int N     = 16,
  parameter int IDX_W = 4
) (
  input  logic [N-1:0]     match,
  output logic             hit,
  output logic [IDX_W-1:0] pos
);
  import mrucd_pkg::*;

  // Stored keys are unique, so at most one bit is set and an OR per bit encodes it.
  always_comb begin
    pos = '0;
    for (int b = 0; b < IDX_W; b++) begin
      for (int i = 0; i < N; i++) begin
        if (((i >> b) & 1) == 1) begin
          pos[b] = pos[b] | match[i];
        end
      end
    end
  end

  assign hit = |match;

endmodule

// File: rtl/mru_replacement_cache_directory_top.sv
// MRU cache directory top level: a row of key cells, a lookup encoder and the access sequencer.
// Each transaction is accepted, then compared and encoded across the cell row, then applied as an
// update, which waits while an earlier result is still held on the output. A new access is taken
// only once the last one has been updated and its result registered for out_tvalid.
// Synchronous active-low reset clears occupancy, both counters, the sequencer and the output
// valid flag and sets capacity to 16; cell keys are not reset and are never read before written.
module mru_replacement_cache_directory_top #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input stream. in_tdata: access_key[7:0].
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [mrucd_pkg::KEY_W-1:0]            in_tdata,
  // Result stream. out_tdata: hit[0], evict_valid[1], evicted_key[9:2], hit_total[41:10],
  // miss_total[73:42], fill_level[78:74], zero pad[79].
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [mrucd_pkg::OUT_DATA_W-1:0]       out_tdata,
  // Configuration port.
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [mrucd_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [mrucd_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [mrucd_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                   cfg_pready
);
  import mrucd_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic                  hit_r, hit_nxt;
  logic [IDX_W-1:0]      pos_r, pos_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CTR_W-1:0]      hit_ctr_r, hit_ctr_nxt;
  logic [CTR_W-1:0]      miss_ctr_r, miss_ctr_nxt;
  logic [CNT_W-1:0]      cap_r, cap_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [MAX_ENTRIES-1:0] cell_match;
  logic [MAX_ENTRIES-1:0] cell_valid;
  logic [KEY_W-1:0]       cell_key [MAX_ENTRIES];
  mrucd_cell_ctrl_t       cell_ctrl [MAX_ENTRIES];
  logic                   enc_hit;
  logic [IDX_W-1:0]       enc_pos;

  logic                   cfg_write;
  logic                   upd_go;
  logic [CNT_W-1:0]       cap_eff;
  logic                   evict;
  logic [31:0]            shift_lim;
  logic [KEY_W-1:0]       evicted_key;

  // Configuration register: written in the APB access phase, read back combinationally.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == REG_CAPACITY_ADDR);
  assign cap_nxt    = cfg_write ? cfg_pwdata[CNT_W-1:0] : cap_r;
  assign cfg_prdata = (cfg_paddr == REG_CAPACITY_ADDR) ?
                      {{(CFG_DATA_W-CNT_W){1'b0}}, cap_r} : '0;

  // Effective capacity: zero acts as one, anything above the cell count acts as the cell count.
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(cap_r) > 32'(MAX_ENTRIES)) begin
      cap_eff = CNT_W'(MAX_ENTRIES);
    end else begin
      cap_eff = cap_r;
    end
  end

  // Row of cells; the front cell loads the looked-up key, each other cell shifts from its more recent neighbor.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    assign cell_valid[i] = (32'(count_r) > 32'(i));
    if (i == 0) begin : g_front
      mrucd_cell u_cell (
        .clk          (clk),
        .entry_valid  (cell_valid[i]),
        .lookup_key   (key_r),
        .neighbor_key (key_r),
        .ctrl         (cell_ctrl[i]),
        .key          (cell_key[i]),
        .match        (cell_match[i])
      );
    end else begin : g_rest
      mrucd_cell u_cell (
        .clk          (clk),
        .entry_valid  (cell_valid[i]),
        .lookup_key   (key_r),
        .neighbor_key (cell_key[i-1]),
        .ctrl         (cell_ctrl[i]),
        .key          (cell_key[i]),
        .match        (cell_match[i])
      );
    end
  end

  mrucd_pos_enc #(
    .N     (MAX_ENTRIES),
    .IDX_W (IDX_W)
  ) u_pos_enc (
    .match (cell_match),
    .hit   (enc_hit),
    .pos   (enc_pos)
  );

  // Update decision: how far down the row the keys move.
  assign upd_go      = (state_r == ST_UPD) && (!out_valid_r || out_tready);
  assign evict       = !hit_r && (count_r >= cap_eff);
  assign evicted_key = evict ? cell_key[0] : '0;

  always_comb begin
    if (hit_r) begin
      shift_lim = 32'(pos_r);
    end else if (evict) begin
      shift_lim = '0;
    end else begin
      shift_lim = 32'(count_r);
    end
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_ctrl
    if (i == 0) begin : g_front
      assign cell_ctrl[i].load  = upd_go;
      assign cell_ctrl[i].shift = 1'b0;
    end else begin : g_rest
      assign cell_ctrl[i].load  = 1'b0;
      assign cell_ctrl[i].shift = upd_go && (32'(i) <= shift_lim);
    end
  end

  // Access sequencer, counters and output register.
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    hit_nxt       = hit_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    hit_ctr_nxt   = hit_ctr_r;
    miss_ctr_nxt  = miss_ctr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          key_nxt   = in_tdata;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        hit_nxt   = enc_hit;
        pos_nxt   = enc_pos;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (upd_go) begin
          if (hit_r) begin
            if (hit_ctr_r != '1) begin
              hit_ctr_nxt = hit_ctr_r + CTR_W'(1);
            end
          end else begin
            if (miss_ctr_r != '1) begin
              miss_ctr_nxt = miss_ctr_r + CTR_W'(1);
            end
            if (!evict) begin
              count_nxt = count_r + CNT_W'(1);
            end
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({count_nxt, miss_ctr_nxt, hit_ctr_nxt,
                                       evicted_key, evict, hit_r});
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      hit_ctr_r   <= '0;
      miss_ctr_r  <= '0;
      cap_r       <= CAPACITY_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      hit_ctr_r   <= hit_ctr_nxt;
      miss_ctr_r  <= miss_ctr_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    hit_r      <= hit_nxt;
    pos_r      <= pos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: bench/testbench.sv
// Self-checking bench for mru_replacement_cache_directory_top: drives access keys and capacity
// writes, predicts every lookup result in place and compares them field by field.
// Depends on rtl/mrucd_pkg.sv and rtl/mru_replacement_cache_directory_top.sv.
`timescale 1ns / 1ps

module testbench;
  import mrucd_pkg::*;

  localparam int DIR_DEPTH   = 16;
  localparam int POOL_SIZE   = 20;
  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD   = 200;

  // Lookup result laid out as on out_tdata, lowest bit (hit) last.
  typedef struct packed {
    logic [CNT_W-1:0] fill_level;
    logic [CTR_W-1:0] miss_total;
    logic [CTR_W-1:0] hit_total;
    logic [KEY_W-1:0] evicted_key;
    logic             evict_valid;
    logic             hit;
  } lookup_result_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [KEY_W-1:0]      in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Directory model: keys in recency order, position 0 most recent.
  logic [KEY_W-1:0] dir_keys [DIR_DEPTH];
  logic [CNT_W-1:0] dir_fill = '0;
  logic [CTR_W-1:0] hits_seen = '0;
  logic [CTR_W-1:0] misses_seen = '0;
  logic [CNT_W-1:0] capacity_setting = CAPACITY_RESET;

  logic [KEY_W-1:0] access_keys_to_send [$];
  lookup_result_t   expected_lookups [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  int  fail_count = 0;
  int  quiet_cycles = 0;
  bit  send_idle_on = 1'b0;
  bit  recv_idle_on = 1'b0;
  int  tx_gap_left = 0;
  int  rx_stall_left = 0;
  int  rx_hold_left = 0;
  int  rx_hold_requests = 0;
  int  rx_holds_done = 0;

  mru_replacement_cache_directory_top #(.MAX_ENTRIES(DIR_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // access_key[7:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // hit, evict_valid, evicted_key, hit_total, miss_total, fill_level
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int pick_idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  // Keys come mostly from a small pool so that hits are common.
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return KEY_W'($urandom);
  endfunction

  // Capacity value with random upper bits, which the register must drop.
  function automatic logic [CFG_DATA_W-1:0] with_noise(logic [CNT_W-1:0] value);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom;
    word[CNT_W-1:0] = value;
    return word;
  endfunction

  // Looks the key up in the directory model, updates it and returns the expected result.
  function automatic lookup_result_t predict_access(logic [KEY_W-1:0] key);
    lookup_result_t r;
    int             cap_eff;
    int             pos;
    bit             found;
    r = '0;
    pos = 0;
    found = 1'b0;
    if (capacity_setting == 0) cap_eff = 1;
    else if (capacity_setting > DIR_DEPTH) cap_eff = DIR_DEPTH;
    else cap_eff = int'(capacity_setting);
    for (int i = 0; i < dir_fill; i++) begin
      if (!found && dir_keys[i] == key) begin
        found = 1'b1;
        pos = i;
      end
    end
    if (found) begin
      for (int i = pos; i > 0; i--) dir_keys[i] = dir_keys[i-1];
      dir_keys[0] = key;
      if (hits_seen != '1) hits_seen = hits_seen + 1'b1;
      r.hit = 1'b1;
    end else begin
      if (misses_seen != '1) misses_seen = misses_seen + 1'b1;
      if (dir_fill >= cap_eff) begin
        // Full, or capacity lowered below occupancy: the most recent key is replaced.
        r.evict_valid = 1'b1;
        r.evicted_key = dir_keys[0];
        dir_keys[0] = key;
      end else begin
        for (int i = int'(dir_fill); i > 0; i--) dir_keys[i] = dir_keys[i-1];
        dir_keys[0] = key;
        dir_fill = dir_fill + 1'b1;
      end
    end
    r.hit_total = hits_seen;
    r.miss_total = misses_seen;
    r.fill_level = dir_fill;
    return r;
  endfunction

  function automatic bit check_field(string name, logic [CTR_W-1:0] want, logic [CTR_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Access driver: holds a key until it is taken, then, when idling is on, may insert a random gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (tx_gap_left > 0) begin
        tx_gap_left = tx_gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (access_keys_to_send.size() > 0) begin
        in_tdata <= access_keys_to_send.pop_front();
        in_tvalid <= 1'b1;
        if (send_idle_on && $urandom_range(0, 99) < 30) tx_gap_left = pick_idle_length();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (rx_holds_done != rx_hold_requests) begin
        rx_holds_done = rx_holds_done + 1;
        rx_hold_left = LONG_HOLD;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left = rx_hold_left - 1;
        out_tready <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left = rx_stall_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (recv_idle_on && $urandom_range(0, 99) < 25) rx_stall_left = pick_idle_length();
      end
    end
  end

  // Predict on each accepted access, compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    lookup_result_t want;
    lookup_result_t got;
    bit             mismatch;
    if (rst_n) begin
      if (in_tvalid && in_tready) expected_lookups = {expected_lookups, predict_access(in_tdata)};
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(lookup_result_t)-1:0];
        if (expected_lookups.size() == 0) begin
          $error("lookup result arrived with no access outstanding");
          fail_count++;
        end else begin
          want = expected_lookups.pop_front();
          mismatch = check_field("hit", CTR_W'(want.hit), CTR_W'(got.hit));
          mismatch |= check_field("evict_valid", CTR_W'(want.evict_valid),
                                  CTR_W'(got.evict_valid));
          mismatch |= check_field("evicted_key", CTR_W'(want.evicted_key),
                                  CTR_W'(got.evicted_key));
          mismatch |= check_field("hit_total", want.hit_total, got.hit_total);
          mismatch |= check_field("miss_total", want.miss_total, got.miss_total);
          mismatch |= check_field("fill_level", CTR_W'(want.fill_level),
                                  CTR_W'(got.fill_level));
          if (mismatch) fail_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Waits until every queued access is sent and every result has come back.
  task automatic wait_until_idle();
    do @(posedge clk);
    while (access_keys_to_send.size() != 0 || in_tvalid || expected_lookups.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Setup cycle, access cycle, then the write lands on the edge with pready high.
  task automatic write_capacity(input logic [CFG_DATA_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_CAPACITY_ADDR;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    capacity_setting = value[CNT_W-1:0];
    @(posedge clk);
  endtask

  task automatic queue_random_accesses(input int count);
    repeat (count) access_keys_to_send = {access_keys_to_send, pick_key()};
  endtask

  initial begin
    for (int i = 0; i < DIR_DEPTH; i++) dir_keys[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, back to back on both sides.
    // Capacity zero acts as one: the second miss replaces the only entry.
    write_capacity(32'd0);
    access_keys_to_send = '{8'h00, 8'hFF, 8'hFF, 8'h00};
    wait_until_idle();
    write_capacity(32'd1);
    access_keys_to_send = '{8'h00, 8'h33};
    wait_until_idle();
    // Small capacity: fill to three, then a miss replaces the most recent key.
    write_capacity(32'd3);
    access_keys_to_send = '{8'h01, 8'h02, 8'h80, 8'h01};
    wait_until_idle();
    // Capacity above the directory size acts as full size; fill, evict, hit the oldest.
    write_capacity(32'hFFFF_FFFF);
    access_keys_to_send = '{8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'hFE, 8'hFD, 8'hFB,
                           8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F, 8'hAA, 8'h33};
    wait_until_idle();

    // Random part in five phases with different capacities and idling.
    for (int phase = 0; phase < 5; phase++) begin
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);
      send_idle_on = (phase != 3);
      recv_idle_on = (phase != 3);
      case (phase)
        0: write_capacity(with_noise(5'd17));
        1: write_capacity(with_noise(5'd16));
        2: write_capacity(with_noise(CNT_W'($urandom_range(0, 31))));
        3: write_capacity(with_noise(5'd1));
        default: write_capacity(with_noise(CNT_W'($urandom_range(2, 15))));
      endcase
      if (phase == 1) begin
        // Receiver holds off while accesses keep coming, then the sender drains fully.
        queue_random_accesses(55);
        rx_hold_requests++;
        wait_until_idle();
        queue_random_accesses(55);
      end else begin
        queue_random_accesses(110);
      end
      wait_until_idle();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mrucd_pkg.sv
rtl/mrucd_cell.sv
rtl/mrucd_pos_enc.sv
rtl/mru_replacement_cache_directory_top.sv
bench/testbench.sv
